@@ hdl/assert_macros.svh @@
// Assertion macros shared by the block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, ignored while reset is applied.
`define MBRM_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define MBRM_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/mbrm_pkg.sv @@
// Types, codes and helper functions of the Modbus RTU read master.
package mbrm_pkg;

	// Default receive buffer depth in bytes.
	localparam int RX_BYTES_DEF = 64;
	// Width of a byte count; covers the largest buffer depth.
	localparam int LEN_W = 7;
	// Width of a buffer address at the largest depth.
	localparam int ADDR_W = 6;

	localparam logic [7:0]  FUNC_HOLDING = 8'h03;
	localparam logic [7:0]  FUNC_INPUT   = 8'h04;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;
	localparam logic [LEN_W-1:0] MIN_FRAME   = 7'd3;
	localparam logic [LEN_W-1:0] PAYLOAD_OFS = 7'd3;

	// Input item codes.
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_TICK  = 2'd2,
		OP_POLL  = 2'd3
	} op_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_TX      = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_STATUS  = 2'd2
	} kind_t;

	// Status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_CRC   = 2'd1,
		ST_SHORT = 2'd2
	} status_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_SLAVE_ID    = 2'd0,
		CFG_FRAME_GAP   = 2'd1,
		CFG_RETRY_LIMIT = 2'd2
	} cfg_idx_t;

	// Work handed from the front to the back.
	typedef enum logic [1:0] {
		JOB_TX    = 2'd0,
		JOB_CHECK = 2'd1,
		JOB_SHORT = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t        kind;
		logic [LEN_W-1:0] len;
		logic [7:0]       slave;
		logic             func;
		logic [15:0]      addr;
		logic [6:0]       count;
	} job_t;

	// Receive buffer write request.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	// Outcome of a frame check.
	typedef struct packed {
		logic valid;
		logic ok;
	} done_t;

	// Back end sequencer states.
	typedef enum logic [3:0] {
		B_IDLE, B_TX, B_RD, B_CRC, B_CMP, B_PRD, B_PAY, B_STAT, B_DONE
	} back_state_t;

	// CRC-16/Modbus update by one byte.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ hdl/mbrm_jobq.sv @@
// Two-entry job queue between the front and the back.
`include "assert_macros.svh"
module mbrm_jobq import mbrm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic not_empty,
	output logic full,
	output job_t head
);

	job_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign not_empty = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign head      = mem_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	`MBRM_ASSERT(a_no_push_full, push |-> !full, "job pushed into a full queue")
	`MBRM_ASSERT(a_no_pop_empty, pop |-> not_empty, "job popped from an empty queue")
	`MBRM_ASSERT_ALWAYS(a_cnt_range, cnt_q != 2'd3, "job queue level out of range")

endmodule

@@ hdl/mbrm_front.sv @@
// Front end: accepts items, keeps the protocol state and issues jobs.
module mbrm_front import mbrm_pkg::*; #(
	parameter int RX_BUFFER_BYTES = RX_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic        input_regs,
	input  logic [15:0] start_address,
	input  logic [6:0]  register_count,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        job_push,
	output job_t        job,
	input  logic        job_full,
	input  done_t       done,
	output wr_t         wr
);

	localparam logic [LEN_W-1:0] DEPTH = LEN_W'(RX_BUFFER_BYTES);

	logic [7:0]       slave_q;
	logic [15:0]      gap_q;
	logic [7:0]       retry_q;
	logic             func_q;
	logic [15:0]      addr_q;
	logic [6:0]       count_q;
	logic             send_q;
	logic             await_q;
	logic             active_q;
	logic [31:0]      ms_q;
	logic [31:0]      start_q;
	logic [LEN_W-1:0] rxlen_q;
	logic [7:0]       poll_q;
	logic             wait_q;

	logic        acc;
	logic        is_poll;
	logic [31:0] diff;
	logic [31:0] elapsed;
	logic        gap_done;
	logic [7:0]  poll_inc;
	logic        close_frame;
	logic        short_frame;

	assign cfg_ready = 1'b1;
	assign in_stall  = wait_q | job_full;
	assign acc       = in_valid & ~in_stall;
	assign is_poll   = acc && (op_t'(opcode) == OP_POLL);

	// Time since the first byte of the frame, with the wrap rule.
	assign diff     = ms_q - start_q;
	assign elapsed  = (ms_q >= start_q) ? diff : diff - 32'd1;
	assign gap_done = elapsed >= {16'h0000, gap_q};
	assign poll_inc = poll_q + 8'd1;

	assign close_frame = !send_q && await_q && active_q && gap_done;
	assign short_frame = rxlen_q < MIN_FRAME;

	// Job issue.
	always_comb begin
		job_push  = 1'b0;
		job.kind  = JOB_TX;
		job.len   = rxlen_q;
		job.slave = slave_q;
		job.func  = func_q;
		job.addr  = addr_q;
		job.count = count_q;
		if (is_poll && send_q) begin
			job_push = 1'b1;
		end else if (is_poll && close_frame) begin
			job_push = 1'b1;
			job.kind = short_frame ? JOB_SHORT : JOB_CHECK;
		end
	end

	// Buffer write for a received byte that fits.
	always_comb begin
		wr.en   = acc && (op_t'(opcode) == OP_BYTE) && (rxlen_q < DEPTH);
		wr.addr = rxlen_q[ADDR_W-1:0];
		wr.data = rx_byte;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= 8'd1;
			gap_q   <= 16'd20;
			retry_q <= 8'd5;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SLAVE_ID:    slave_q <= cfg_data[7:0];
				CFG_FRAME_GAP:   gap_q   <= cfg_data;
				CFG_RETRY_LIMIT: retry_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Request and link state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q   <= 1'b0;
			addr_q   <= '0;
			count_q  <= '0;
			send_q   <= 1'b0;
			await_q  <= 1'b0;
			active_q <= 1'b0;
			ms_q     <= '0;
			start_q  <= '0;
			rxlen_q  <= '0;
			poll_q   <= '0;
			wait_q   <= 1'b0;
		end else begin
			if (done.valid) begin
				wait_q  <= 1'b0;
				await_q <= 1'b0;
				if (done.ok) begin
					send_q <= 1'b0;
					poll_q <= '0;
				end else begin
					send_q <= 1'b1;
				end
			end
			if (acc) begin
				case (op_t'(opcode))
					OP_START: begin
						func_q  <= input_regs;
						addr_q  <= start_address;
						count_q <= register_count;
						send_q  <= 1'b1;
						await_q <= 1'b0;
						poll_q  <= '0;
					end
					OP_BYTE: begin
						if (!active_q) begin
							active_q <= 1'b1;
							start_q  <= ms_q;
						end
						if (rxlen_q >= DEPTH) begin
							rxlen_q <= '0;
						end else begin
							rxlen_q <= rxlen_q + LEN_W'(1);
						end
					end
					OP_TICK: begin
						ms_q <= ms_q + 32'd1;
					end
					OP_POLL: begin
						if (send_q) begin
							rxlen_q <= '0;
							send_q  <= 1'b0;
							await_q <= 1'b1;
						end else if (await_q) begin
							if (poll_inc > retry_q) begin
								poll_q  <= '0;
								send_q  <= 1'b1;
								await_q <= 1'b0;
							end else begin
								poll_q <= poll_inc;
							end
							if (close_frame) begin
								active_q <= 1'b0;
								rxlen_q  <= '0;
								if (short_frame) begin
									send_q  <= 1'b1;
									await_q <= 1'b0;
								end else begin
									wait_q <= 1'b1;
								end
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

@@ hdl/mbrm_back.sv @@
// Back end: sends request frames and checks received frames from the buffer.
`include "assert_macros.svh"
module mbrm_back import mbrm_pkg::*; #(
	parameter int RX_BUFFER_BYTES = RX_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	input  job_t        job_in,
	output logic        job_pop,
	input  wr_t         wr,
	output done_t       done,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [1:0]  status,
	output logic        last
);

	localparam int AW = $clog2(RX_BUFFER_BYTES);

	logic [7:0] mem_q [RX_BUFFER_BYTES];

	back_state_t      state_q;
	back_state_t      state_d;
	job_t             job_q;
	logic [LEN_W-1:0] idx_q;
	logic [15:0]      crc_q;
	logic [15:0]      got_q;
	logic [7:0]       rd_data_q;
	status_t          code_q;
	logic             ok_q;
	logic             out_valid_q;
	kind_t            kind_q;
	logic [7:0]       data_q;
	status_t          status_q;
	logic             last_q;

	logic             can_load;
	logic             ld;
	kind_t            ld_kind;
	logic [7:0]       ld_data;
	status_t          ld_status;
	logic             ld_last;
	logic             rd_en;
	logic [7:0]       tx_byte;
	logic [LEN_W-1:0] crc_end;
	logic [LEN_W-1:0] idx_next;

	assign can_load  = ~out_valid_q | ~out_stall;
	assign crc_end   = job_q.len - LEN_W'(2);
	assign idx_next  = idx_q + LEN_W'(1);
	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign data_byte = data_q;
	assign status    = status_q;
	assign last      = last_q;

	// Request frame byte by position.
	always_comb begin
		case (idx_q[2:0])
			3'd0:    tx_byte = job_q.slave;
			3'd1:    tx_byte = job_q.func ? FUNC_INPUT : FUNC_HOLDING;
			3'd2:    tx_byte = job_q.addr[15:8];
			3'd3:    tx_byte = job_q.addr[7:0];
			3'd4:    tx_byte = 8'h00;
			3'd5:    tx_byte = {1'b0, job_q.count};
			3'd6:    tx_byte = crc_q[7:0];
			default: tx_byte = crc_q[15:8];
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					case (job_in.kind)
						JOB_TX:    state_d = B_TX;
						JOB_CHECK: state_d = B_RD;
						default:   state_d = B_STAT;
					endcase
				end
			end
			B_TX:  if (can_load && idx_q[2:0] == 3'd7) state_d = B_IDLE;
			B_RD:  state_d = B_CRC;
			B_CRC: state_d = (idx_q == job_q.len - LEN_W'(1)) ? B_CMP : B_RD;
			B_CMP: state_d = (crc_q == got_q) ? B_PRD : B_STAT;
			B_PRD: state_d = (idx_q + LEN_W'(2) < job_q.len) ? B_PAY : B_STAT;
			B_PAY: if (can_load) state_d = B_PRD;
			B_STAT: begin
				if (can_load) begin
					state_d = (job_q.kind == JOB_CHECK) ? B_DONE : B_IDLE;
				end
			end
			B_DONE:  state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// Outputs of each state.
	always_comb begin
		job_pop    = 1'b0;
		ld         = 1'b0;
		ld_kind    = KIND_TX;
		ld_data    = 8'h00;
		ld_status  = ST_OK;
		ld_last    = 1'b0;
		rd_en      = 1'b0;
		done.valid = 1'b0;
		done.ok    = ok_q;
		case (state_q)
			B_IDLE: job_pop = job_valid;
			B_TX: begin
				ld      = can_load;
				ld_data = tx_byte;
				ld_last = (idx_q[2:0] == 3'd7);
			end
			B_RD:  rd_en = 1'b1;
			B_PRD: rd_en = (idx_q + LEN_W'(2) < job_q.len);
			B_PAY: begin
				ld      = can_load;
				ld_kind = KIND_PAYLOAD;
				ld_data = rd_data_q;
			end
			B_STAT: begin
				ld        = can_load;
				ld_kind   = KIND_STATUS;
				ld_status = code_q;
				ld_last   = 1'b1;
			end
			B_DONE:  done.valid = 1'b1;
			default: ;
		endcase
	end

	// Receive buffer with a registered read port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr[AW-1:0]] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[idx_q[AW-1:0]];
		end
	end

	// Sequencer datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					job_q  <= job_in;
					idx_q  <= '0;
					crc_q  <= CRC_INIT;
					code_q <= ST_SHORT;
					ok_q   <= 1'b0;
				end
			end
			B_TX: begin
				if (can_load) begin
					idx_q <= idx_next;
					if (idx_q < LEN_W'(6)) begin
						crc_q <= crc_byte(crc_q, tx_byte);
					end
				end
			end
			B_CRC: begin
				if (idx_q < crc_end) begin
					crc_q <= crc_byte(crc_q, rd_data_q);
				end else if (idx_q == crc_end) begin
					got_q[7:0] <= rd_data_q;
				end else begin
					got_q[15:8] <= rd_data_q;
				end
				idx_q <= idx_next;
			end
			B_CMP: begin
				idx_q <= PAYLOAD_OFS;
				ok_q  <= (crc_q == got_q);
				code_q <= (crc_q == got_q) ? ST_OK : ST_CRC;
			end
			B_PAY: if (can_load) idx_q <= idx_next;
			default: ;
		endcase
	end

	// Control state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			kind_q   <= ld_kind;
			data_q   <= ld_data;
			status_q <= ld_status;
			last_q   <= ld_last;
		end
	end

	`MBRM_ASSERT(a_stat_last, out_valid_q && kind_q == KIND_STATUS |-> last_q,
		"status result without last")
	`MBRM_ASSERT(a_pop_idle, job_pop |-> state_q == B_IDLE, "job taken while busy")
	`MBRM_ASSERT(a_done_idle, done.valid |=> state_q == B_IDLE,
		"sequencer not idle after check outcome")

endmodule

@@ hdl/modbus_rtu_master_read.sv @@
// Top level of the Modbus RTU read master.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  in       | in_valid / in_stall   | opcode, input_regs, start_address,
//           |                       | register_count, rx_byte
//  out      | out_valid / out_stall | kind, data_byte, status, last
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Start, byte and tick items are taken by the front end whenever in_stall is low.
// A send poll gives its 8 frame bytes one per cycle while out_stall lets them
// through, the CRC being updated by each of the first six bytes in the back end sequencer.
// A frame check reads the receive buffer through its registered read port, each
// byte passing through B_RD and B_CRC, then, if the CRC matches, emits payload bytes
// through B_PRD and B_PAY, and the status; input stalls until done.
// Reset is asynchronous and active low; the receive buffer needs no clearing pass.
// A stalled output holds its result; the job queue lets the front take further
// items until it is full or a frame check is awaited.
module modbus_rtu_master_read import mbrm_pkg::*; #(
	parameter int RX_BUFFER_BYTES = RX_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic        input_regs,
	input  logic [15:0] start_address,
	input  logic [6:0]  register_count,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [1:0]  status,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic  job_push;
	job_t  job_new;
	logic  job_full;
	logic  job_valid;
	job_t  job_head;
	logic  job_pop;
	done_t done;
	wr_t   wr;

	// Item intake and protocol state.
	mbrm_front #(
		.RX_BUFFER_BYTES(RX_BUFFER_BYTES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.input_regs     (input_regs),
		.start_address  (start_address),
		.register_count (register_count),
		.rx_byte        (rx_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.job_push       (job_push),
		.job            (job_new),
		.job_full       (job_full),
		.done           (done),
		.wr             (wr)
	);

	// Job queue.
	mbrm_jobq u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_job  (job_new),
		.pop       (job_pop),
		.not_empty (job_valid),
		.full      (job_full),
		.head      (job_head)
	);

	// Frame transmit and check sequencer.
	mbrm_back #(
		.RX_BUFFER_BYTES(RX_BUFFER_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_in    (job_head),
		.job_pop   (job_pop),
		.wr        (wr),
		.done      (done),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.data_byte (data_byte),
		.status    (status),
		.last      (last)
	);

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the Modbus RTU read master, with its scoreboard class.
module testbench;
	import mbrm_pkg::*;

	localparam int BUF_BYTES = 64;
	localparam int IDLE_WAIT = 400;
	localparam int HANG_LIMIT = 6000;

	// One expected result of the block.
	typedef struct {
		kind_t       kind;
		logic [7:0]  data;
		status_t     st;
		logic        last;
	} mb_result_t;

	// Scoreboard: tracks the master's state and holds the results it owes.
	class mb_scoreboard;
		logic [7:0]  slave_id;
		logic [15:0] frame_gap;
		logic [7:0]  retry_limit;
		logic        req_input;
		logic [15:0] req_addr;
		logic [6:0]  req_count;
		logic        send_pending;
		logic        awaiting;
		logic        frame_open;
		logic [31:0] ms_now;
		logic [31:0] frame_start;
		logic [6:0]  rx_len;
		logic [7:0]  rx_buf [BUF_BYTES];
		logic [7:0]  poll_cnt;
		mb_result_t  owed [$];
		int          fails;

		function new();
			slave_id = 8'd1;
			frame_gap = 16'd20;
			retry_limit = 8'd5;
			req_input = 1'b0;
			req_addr = '0;
			req_count = '0;
			send_pending = 1'b0;
			awaiting = 1'b0;
			frame_open = 1'b0;
			ms_now = '0;
			frame_start = '0;
			rx_len = '0;
			poll_cnt = '0;
			fails = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [15:0] value);
			case (idx)
				CFG_SLAVE_ID:    slave_id = value[7:0];
				CFG_FRAME_GAP:   frame_gap = value;
				CFG_RETRY_LIMIT: retry_limit = value[7:0];
				default: ;
			endcase
		endfunction

		// CRC-16 as used on the Modbus serial line, reflected polynomial.
		function logic [15:0] frame_crc(logic [7:0] bytes [], int unsigned n);
			logic [15:0] c;
			c = 16'hFFFF;
			for (int unsigned i = 0; i < n; i++) begin
				c = c ^ {8'h00, bytes[i]};
				for (int b = 0; b < 8; b++)
					c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
			end
			return c;
		endfunction

		function void owe(kind_t k, logic [7:0] d, status_t s, logic l);
			mb_result_t r;
			r.kind = k;
			r.data = d;
			r.st = s;
			r.last = l;
			owed.push_back(r);
		endfunction

		// Advances the state by one accepted request and queues its results.
		function void note_request(op_t op, logic ir, logic [15:0] addr, logic [6:0] cnt,
				logic [7:0] rxb);
			logic [7:0]  f [];
			logic [7:0]  rx [];
			logic [15:0] crc;
			logic [31:0] elapsed;
			int unsigned n;
			case (op)
				OP_START: begin
					req_input = ir;
					req_addr = addr;
					req_count = cnt;
					send_pending = 1'b1;
					awaiting = 1'b0;
					poll_cnt = '0;
				end
				OP_BYTE: begin
					if (!frame_open) begin
						frame_open = 1'b1;
						frame_start = ms_now;
					end
					if (rx_len >= BUF_BYTES) begin
						rx_len = '0;
					end else begin
						rx_buf[rx_len[5:0]] = rxb;
						rx_len = rx_len + 7'd1;
					end
				end
				OP_TICK: ms_now = ms_now + 32'd1;
				default: begin
					// A pending send goes out first, before any waiting logic.
					if (send_pending) begin
						f = new[8];
						f[0] = slave_id;
						f[1] = req_input ? FUNC_INPUT : FUNC_HOLDING;
						f[2] = req_addr[15:8];
						f[3] = req_addr[7:0];
						f[4] = 8'h00;
						f[5] = {1'b0, req_count};
						crc = frame_crc(f, 6);
						f[6] = crc[7:0];
						f[7] = crc[15:8];
						for (int i = 0; i < 8; i++)
							owe(KIND_TX, f[i], ST_OK, i == 7);
						rx_len = '0;
						send_pending = 1'b0;
						awaiting = 1'b1;
						return;
					end
					if (!awaiting)
						return;
					poll_cnt = poll_cnt + 8'd1;
					if (poll_cnt > retry_limit) begin
						poll_cnt = '0;
						send_pending = 1'b1;
						awaiting = 1'b0;
					end
					if (!frame_open)
						return;
					if (ms_now >= frame_start)
						elapsed = ms_now - frame_start;
					else
						elapsed = 32'hFFFF_FFFF - frame_start + ms_now;
					if (elapsed < {16'h0000, frame_gap})
						return;
					frame_open = 1'b0;
					n = rx_len;
					if (n < 3) begin
						owe(KIND_STATUS, 8'h00, ST_SHORT, 1'b1);
						send_pending = 1'b1;
						awaiting = 1'b0;
					end else begin
						rx = new[n];
						for (int unsigned i = 0; i < n; i++)
							rx[i] = rx_buf[i];
						crc = frame_crc(rx, n - 2);
						if (crc != {rx[n-1], rx[n-2]}) begin
							owe(KIND_STATUS, 8'h00, ST_CRC, 1'b1);
							send_pending = 1'b1;
							awaiting = 1'b0;
						end else begin
							for (int unsigned i = 3; i + 2 < n; i++)
								owe(KIND_PAYLOAD, rx[i], ST_OK, 1'b0);
							owe(KIND_STATUS, 8'h00, ST_OK, 1'b1);
							send_pending = 1'b0;
							awaiting = 1'b0;
							poll_cnt = '0;
						end
					end
					rx_len = '0;
				end
			endcase
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			fails++;
		endtask

		// Compares one accepted result with the oldest one owed.
		task check_result(logic [1:0] k, logic [7:0] d, logic [1:0] s, logic l);
			mb_result_t e;
			if (owed.size() == 0) begin
				report($sformatf("unexpected result kind %0d data %02h", k, d));
			end else begin
				e = owed.pop_front();
				if (k !== e.kind)
					report($sformatf("kind %0d, expected %0d", k, e.kind));
				if (d !== e.data)
					report($sformatf("data_byte %02h, expected %02h", d, e.data));
				if (s !== e.st)
					report($sformatf("status %0d, expected %0d", s, e.st));
				if (l !== e.last)
					report($sformatf("last %0b, expected %0b", l, e.last));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic        input_regs;
	logic [15:0] start_address;
	logic [6:0]  register_count;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [1:0]  status;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	mb_scoreboard sb;
	int burst_left;
	int stall_mode;
	int stall_left;
	int hang_cnt;
	int req_total;

	modbus_rtu_master_read i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .input_regs(input_regs), .start_address(start_address),
		.register_count(register_count), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .data_byte(data_byte), .status(status), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Clock generation.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver stall pattern: free runs, random stalls and long holds.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(10, 60);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 4);
			default: out_stall <= ($urandom_range(0, 19) != 0);
		endcase
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(kind, data_byte, status, last);
	end

	// Watchdog on cycles without any accepted transfer.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			hang_cnt <= 0;
		end else if (hang_cnt >= HANG_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end else begin
			hang_cnt <= hang_cnt + 1;
		end
	end

	// Sends one request, with bursts and gaps on the sending side.
	task send_req(op_t op, logic ir, logic [15:0] addr, logic [6:0] cnt, logic [7:0] b);
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 14);
		end else begin
			@(negedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode <= op;
		input_regs <= ir;
		start_address <= addr;
		register_count <= cnt;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(op, ir, addr, cnt, b);
		req_total++;
	endtask

	task send_start(logic ir, logic [15:0] addr, logic [6:0] cnt);
		send_req(OP_START, ir, addr, cnt, $urandom);
	endtask

	task send_byte(logic [7:0] b);
		send_req(OP_BYTE, $urandom, $urandom, $urandom, b);
	endtask

	task send_ticks(int n);
		repeat (n) send_req(OP_TICK, $urandom, $urandom, $urandom, $urandom);
	endtask

	task send_poll();
		send_req(OP_POLL, $urandom, $urandom, $urandom, $urandom);
	endtask

	// Sends a reply frame with a given payload size; the CRC may be spoiled.
	task send_reply(int pay, bit spoil);
		logic [7:0]  f [];
		logic [15:0] crc;
		f = new[pay + 5];
		f[0] = sb.slave_id;
		f[1] = sb.req_input ? FUNC_INPUT : FUNC_HOLDING;
		f[2] = 8'(pay);
		for (int i = 3; i < pay + 3; i++)
			f[i] = $urandom;
		crc = sb.frame_crc(f, pay + 3);
		f[pay + 3] = crc[7:0];
		f[pay + 4] = crc[15:8] ^ (spoil ? 8'h01 << $urandom_range(0, 7) : 8'h00);
		foreach (f[i])
			send_byte(f[i]);
	endtask

	// Lets the gap pass, then polls to close the frame.
	task close_frame();
		send_ticks(sb.frame_gap + $urandom_range(0, 1));
		send_poll();
	endtask

	// Waits until every owed result has come and the block has settled.
	task drain();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task write_reg(cfg_idx_t idx, logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task set_regs(logic [7:0] id, logic [15:0] gap, logic [7:0] retries);
		drain();
		write_reg(CFG_SLAVE_ID, {8'h00, id});
		write_reg(CFG_FRAME_GAP, gap);
		write_reg(CFG_RETRY_LIMIT, {8'h00, retries});
	endtask

	// One full request and reply with random content, sometimes broken.
	task random_exchange();
		int pick;
		pick = $urandom_range(0, 9);
		send_start($urandom, $urandom, (pick == 0) ? $urandom : $urandom_range(1, 125));
		send_poll();
		if (pick == 1) begin
			repeat ($urandom_range(1, 2)) send_byte($urandom);
		end else if (pick == 2) begin
			send_reply($urandom_range(0, 12), 1'b1);
		end else if (pick == 3) begin
			repeat ($urandom_range(1, 8))
				send_req(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
		end else begin
			send_reply(($urandom_range(0, 7) == 0) ? 59 : $urandom_range(0, 10), 1'b0);
		end
		close_frame();
		if ($urandom_range(0, 3) == 0)
			send_poll();
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_TICK;
		input_regs = 1'b0;
		start_address = '0;
		register_count = '0;
		rx_byte = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SLAVE_ID;
		cfg_data = '0;
		burst_left = 0;
		stall_mode = 0;
		stall_left = 0;
		hang_cnt = 0;
		req_total = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at reset settings: idle poll, extremes and a short frame.
		send_poll();
		send_start(1'b0, 16'h0000, 7'd1);
		send_start(1'b1, 16'hFFFF, 7'd125);
		send_poll();
		send_byte(8'h00);
		send_byte(8'hFF);
		close_frame();

		// Overflow: a full buffer drops the next byte and starts over.
		set_regs(8'hFF, 16'd1, 8'd0);
		send_start(1'b0, 16'h8001, 7'h7F);
		send_poll();
		repeat (BUF_BYTES + 1) send_byte($urandom);
		send_reply(0, 1'b0);
		close_frame();
		send_poll();

		// Random part with a short gap.
		set_regs($urandom, 16'd2, 8'd3);
		while (req_total < 115)
			random_exchange();

		// Largest gap: frames stay open, polls only retry.
		set_regs(8'hFF, 16'hFFFF, 8'hFF);
		send_start(1'b1, 16'h5A5A, 7'd3);
		send_poll();
		send_reply(0, 1'b0);
		send_ticks(3);
		repeat (4) send_poll();

		drain();
		if (sb.fails == 0 && sb.owed.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule

@@ modbus_rtu_master_read.f @@
+incdir+hdl
hdl/mbrm_pkg.sv
hdl/mbrm_jobq.sv
hdl/mbrm_front.sv
hdl/mbrm_back.sv
hdl/modbus_rtu_master_read.sv
tb/testbench.sv
